[design/apsw_pkg.sv]
// ----------------------------------------------------------------------------
// apsw_pkg - shared types and constants of the affine pixel splat warp
// Frame geometry, splat limits, register map and the command and
// configuration records passed between the front end, queue and write engine.
// ----------------------------------------------------------------------------
package apsw_pkg;

    // Destination frame geometry and splat limit
    localparam int unsigned DEST_WIDTH  = 1024;
    localparam int unsigned DEST_HEIGHT = 1024;
    localparam int unsigned MAX_SPLAT   = 8;

    // Fixed field widths
    localparam int unsigned ACC_W    = 48;   // Q16.32 accumulator
    localparam int unsigned FRAC_W   = 32;
    localparam int unsigned COORD_W  = ACC_W - FRAC_W;
    localparam int unsigned ADDR_W   = 20;
    localparam int unsigned COLOR_W  = 32;
    localparam int unsigned SIZE_W   = 4;    // splat size register
    localparam int unsigned SPLAT_IW = (MAX_SPLAT > 1) ? $clog2(MAX_SPLAT) : 1;

    // Configuration port
    localparam int unsigned PDATA_W   = 64;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned PADDR_W   = REG_IDX_W + 3;

    // Command queue depth
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [ACC_W-1:0]    t_acc;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [COLOR_W-1:0]  t_color;
    typedef logic [SPLAT_IW-1:0] t_sidx;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_COL_STEP_X = 3'd2,
        REG_COL_STEP_Y = 3'd3,
        REG_ROW_STEP_X = 3'd4,
        REG_ROW_STEP_Y = 3'd5,
        REG_SPLAT_W    = 3'd6,
        REG_SPLAT_H    = 3'd7
    } t_reg_idx;

    // Splat extent, each dimension stored as size minus one
    typedef struct packed {
        t_sidx wm1;
        t_sidx hm1;
    } t_splat;

    // Warp map registers seen by the front end
    typedef struct packed {
        t_acc origin_x;
        t_acc origin_y;
        t_acc col_step_x;
        t_acc col_step_y;
        t_acc row_step_x;
        t_acc row_step_y;
    } t_map;

    // One in-bounds pixel: top-left destination address and its color
    typedef struct packed {
        t_addr  addr;
        t_color color;
    } t_cmd;

    // Clamp a splat size register to 1..MAX_SPLAT and return size minus one
    function automatic t_sidx splat_m1(input logic [SIZE_W-1:0] r);
        t_sidx res;
        if (r == '0) begin
            res = '0;
        end else if (r > SIZE_W'(MAX_SPLAT)) begin
            res = SPLAT_IW'(MAX_SPLAT - 1);
        end else begin
            res = SPLAT_IW'(r - 1'b1);
        end
        return res;
    endfunction

endpackage

[design/affine_pixel_splat_warp_top.sv]
// ----------------------------------------------------------------------------
// affine_pixel_splat_warp_top - forward affine pixel splat warp
// Maps raster-order source pixels onto a destination frame and emits one
// write per cell of a splat block for every pixel that lands in bounds.
// ----------------------------------------------------------------------------
// Usage: a source pixel transfers on every cycle with push high and full low,
// so the pixel side runs at one pixel per cycle as long as the command queue
// has room. Each in-bounds pixel costs one write per splat cell in the write
// engine, one write per cycle while pop keeps the output free, which sets the
// sustained rate for larger splats; out-of-bounds pixels never reach the write
// engine. A pixel's first write passes the queue, the cell registers and the
// output register. A four-entry queue separates the two sides, so full rises
// only when the write engine falls behind. The origin registers take effect
// at the next frame start, the step and splat registers at once; write them
// only while no work is outstanding. Registers sit at byte address 8*index.
// ----------------------------------------------------------------------------
module affine_pixel_splat_warp_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // pixel side
    input  logic                             push,
    output logic                             full,
    input  logic [apsw_pkg::COLOR_W-1:0]     i_pixel_color,
    input  logic                             i_end_of_row,
    input  logic                             i_end_of_frame,
    // write side
    output logic                             empty,
    input  logic                             pop,
    output logic [apsw_pkg::ADDR_W-1:0]      o_write_address,
    output logic [apsw_pkg::COLOR_W-1:0]     o_write_color,
    output logic                             o_last_write,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [apsw_pkg::PADDR_W-1:0]     paddr,
    input  logic [apsw_pkg::PDATA_W-1:0]     pwdata,
    output logic [apsw_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);
    import apsw_pkg::*;

    t_acc              r_origin_x, r_origin_y;
    t_acc              r_col_step_x, r_col_step_y;
    t_acc              r_row_step_x, r_row_step_y;
    logic [SIZE_W-1:0] r_splat_w, r_splat_h;

    t_map     map;
    t_splat   splat;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     accept;
    logic     cmd_push, cmd_valid, cmd_pop;
    t_cmd     cmd_in, cmd_out;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register writes complete on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_col_step_x <= ACC_W'(64'h1_0000_0000);
            r_col_step_y <= '0;
            r_row_step_x <= '0;
            r_row_step_y <= ACC_W'(64'h1_0000_0000);
            r_splat_w    <= SIZE_W'(1);
            r_splat_h    <= SIZE_W'(1);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ORIGIN_X:   r_origin_x   <= pwdata[ACC_W-1:0];
                REG_ORIGIN_Y:   r_origin_y   <= pwdata[ACC_W-1:0];
                REG_COL_STEP_X: r_col_step_x <= pwdata[ACC_W-1:0];
                REG_COL_STEP_Y: r_col_step_y <= pwdata[ACC_W-1:0];
                REG_ROW_STEP_X: r_row_step_x <= pwdata[ACC_W-1:0];
                REG_ROW_STEP_Y: r_row_step_y <= pwdata[ACC_W-1:0];
                REG_SPLAT_W:    r_splat_w    <= pwdata[SIZE_W-1:0];
                REG_SPLAT_H:    r_splat_h    <= pwdata[SIZE_W-1:0];
                default:        r_splat_h    <= r_splat_h;
            endcase
        end
    end

    // read back the addressed register, zero extended
    always_comb begin
        case (reg_idx)
            REG_ORIGIN_X:   prdata = PDATA_W'(r_origin_x);
            REG_ORIGIN_Y:   prdata = PDATA_W'(r_origin_y);
            REG_COL_STEP_X: prdata = PDATA_W'(r_col_step_x);
            REG_COL_STEP_Y: prdata = PDATA_W'(r_col_step_y);
            REG_ROW_STEP_X: prdata = PDATA_W'(r_row_step_x);
            REG_ROW_STEP_Y: prdata = PDATA_W'(r_row_step_y);
            REG_SPLAT_W:    prdata = PDATA_W'(r_splat_w);
            REG_SPLAT_H:    prdata = PDATA_W'(r_splat_h);
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        map.origin_x   = r_origin_x;
        map.origin_y   = r_origin_y;
        map.col_step_x = r_col_step_x;
        map.col_step_y = r_col_step_y;
        map.row_step_x = r_row_step_x;
        map.row_step_y = r_row_step_y;
        // clamp out-of-range splat sizes to 1..MAX_SPLAT
        splat.wm1      = splat_m1(r_splat_w);
        splat.hm1      = splat_m1(r_splat_h);
    end

    // a pixel transfers whenever the queue can take a command
    assign accept = push && !full;

    apsw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_map          (map),
        .i_splat        (splat),
        .i_accept       (accept),
        .i_pixel_color  (i_pixel_color),
        .i_end_of_row   (i_end_of_row),
        .i_end_of_frame (i_end_of_frame),
        .o_cmd_push     (cmd_push),
        .o_cmd          (cmd_in)
    );

    apsw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_out)
    );

    apsw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_splat         (splat),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd_out),
        .o_cmd_pop       (cmd_pop),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_write_address (o_write_address),
        .o_write_color   (o_write_color),
        .o_last_write    (o_last_write)
    );

endmodule

[design/apsw_front.sv]
// ----------------------------------------------------------------------------
// apsw_front - position tracking and bounds classification
// Keeps the Q16.32 row and pixel accumulators, truncates the current
// position toward zero, checks its splat against the frame and issues a command when it fits.
// ----------------------------------------------------------------------------
module apsw_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  apsw_pkg::t_map            i_map,
    input  apsw_pkg::t_splat          i_splat,
    input  logic                      i_accept,
    input  logic [apsw_pkg::COLOR_W-1:0] i_pixel_color,
    input  logic                      i_end_of_row,
    input  logic                      i_end_of_frame,
    output logic                      o_cmd_push,
    output apsw_pkg::t_cmd            o_cmd
);
    import apsw_pkg::*;

    logic r_frame_pending;
    t_acc r_row_x, r_row_y, r_cur_x, r_cur_y;
    t_acc eff_row_x, eff_row_y, eff_cur_x, eff_cur_y;
    t_acc n_row_x, n_row_y;

    logic               x_pos, x_frac, y_pos, y_frac;
    logic [COORD_W-1:0] px, py;
    logic               x_ok, y_ok;

    // A new frame starts from the origin registers as they stand now
    always_comb begin
        eff_row_x = r_frame_pending ? i_map.origin_x : r_row_x;
        eff_row_y = r_frame_pending ? i_map.origin_y : r_row_y;
        eff_cur_x = r_frame_pending ? i_map.origin_x : r_cur_x;
        eff_cur_y = r_frame_pending ? i_map.origin_y : r_cur_y;
        n_row_x   = eff_row_x + i_map.row_step_x;
        n_row_y   = eff_row_y + i_map.row_step_y;
    end

    // Truncation toward zero: values in (-1, 0) land on coordinate 0
    always_comb begin
        x_pos  = ~eff_cur_x[ACC_W-1];
        y_pos  = ~eff_cur_y[ACC_W-1];
        x_frac = (&eff_cur_x[ACC_W-1:FRAC_W]) && (eff_cur_x[FRAC_W-1:0] != '0);
        y_frac = (&eff_cur_y[ACC_W-1:FRAC_W]) && (eff_cur_y[FRAC_W-1:0] != '0);
        px     = x_pos ? eff_cur_x[ACC_W-1:FRAC_W] : '0;
        py     = y_pos ? eff_cur_y[ACC_W-1:FRAC_W] : '0;
        x_ok   = (x_pos || x_frac) &&
                 (({1'b0, px} + (COORD_W+1)'(i_splat.wm1)) < (COORD_W+1)'(DEST_WIDTH));
        y_ok   = (y_pos || y_frac) &&
                 (({1'b0, py} + (COORD_W+1)'(i_splat.hm1)) < (COORD_W+1)'(DEST_HEIGHT));
    end

    assign o_cmd_push  = i_accept && x_ok && y_ok;
    assign o_cmd.addr  = ADDR_W'(ADDR_W'(py) * ADDR_W'(DEST_WIDTH)) + ADDR_W'(px);
    assign o_cmd.color = i_pixel_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pending <= 1'b1;
        end else if (i_accept) begin
            r_frame_pending <= i_end_of_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (i_end_of_row && !i_end_of_frame) begin
                r_row_x <= n_row_x;
                r_row_y <= n_row_y;
                r_cur_x <= n_row_x;
                r_cur_y <= n_row_y;
            end else begin
                r_row_x <= eff_row_x;
                r_row_y <= eff_row_y;
                r_cur_x <= eff_cur_x + i_map.col_step_x;
                r_cur_y <= eff_cur_y + i_map.col_step_y;
            end
        end
    end

endmodule

[design/apsw_queue.sv]
// ----------------------------------------------------------------------------
// apsw_queue - command queue between front end and write engine
// Small register queue so the pixel side and the write side stall apart.
// ----------------------------------------------------------------------------
module apsw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  apsw_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output apsw_pkg::t_cmd  o_cmd
);
    import apsw_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[design/apsw_back.sv]
// ----------------------------------------------------------------------------
// apsw_back - splat write engine
// Walks each command's splat block, rows outer and columns inner, and
// presents one write per cycle through an output register, as long as the output is popped.
// ----------------------------------------------------------------------------
module apsw_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  apsw_pkg::t_splat              i_splat,
    input  logic                          i_cmd_valid,
    input  apsw_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [apsw_pkg::ADDR_W-1:0]   o_write_address,
    output logic [apsw_pkg::COLOR_W-1:0]  o_write_color,
    output logic                          o_last_write
);
    import apsw_pkg::*;

    logic   r_busy, r_out_valid;
    t_sidx  r_u, r_v;
    t_addr  r_row_addr, r_cell_addr, r_out_addr;
    t_color r_color, r_out_color;
    logic   r_out_last;
    logic   emit, last_cell, load;

    always_comb begin
        emit      = r_busy && (!r_out_valid || i_pop);
        last_cell = (r_u == i_splat.wm1) && (r_v == i_splat.hm1);
        load      = i_cmd_valid && (!r_busy || (emit && last_cell));
    end

    assign o_cmd_pop       = load;
    assign o_empty         = !r_out_valid;
    assign o_write_address = r_out_addr;
    assign o_write_color   = r_out_color;
    assign o_last_write    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && last_cell) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_addr  <= r_cell_addr;
            r_out_color <= r_color;
            r_out_last  <= last_cell;
        end
        if (load) begin
            r_row_addr  <= i_cmd.addr;
            r_cell_addr <= i_cmd.addr;
            r_color     <= i_cmd.color;
            r_u         <= '0;
            r_v         <= '0;
        end else if (emit) begin
            if (r_u == i_splat.wm1) begin
                // next splat row
                r_u         <= '0;
                r_v         <= r_v + 1'b1;
                r_row_addr  <= r_row_addr + ADDR_W'(DEST_WIDTH);
                r_cell_addr <= r_row_addr + ADDR_W'(DEST_WIDTH);
            end else begin
                r_u         <= r_u + 1'b1;
                r_cell_addr <= r_cell_addr + 1'b1;
            end
        end
    end

endmodule

[tb/tb_affine_pixel_splat_warp_top.sv]
// ----------------------------------------------------------------------------
// tb_affine_pixel_splat_warp_top - self-checking bench of the affine splat warp
// Streams raster pixels through the pixel queue in random bursts, pops the
// write stream with random stalls and checks every write field by field
// against an in-bench forward-warp predictor. Register settings change
// between phases, from directed corner cases to randomized warp maps.
// ----------------------------------------------------------------------------
module tb_affine_pixel_splat_warp_top;
    import apsw_pkg::*;

    typedef struct {
        t_color color;
        logic   row_end;
        logic   frame_end;
    } t_pixel;

    typedef struct {
        t_addr  addr;
        t_color color;
        logic   last;
    } t_splat_write;

    // Clock, reset and block ports; every input starts at a known value
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                push           = 1'b0;
    logic                full;
    t_color              i_pixel_color  = '0;
    logic                i_end_of_row   = 1'b0;
    logic                i_end_of_frame = 1'b0;
    logic                empty;
    logic                pop            = 1'b0;
    t_addr               o_write_address;
    t_color              o_write_color;
    logic                o_last_write;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [PADDR_W-1:0]  paddr          = '0;
    logic [PDATA_W-1:0]  pwdata         = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Pixels waiting for the driver and writes waiting for the write side
    t_pixel       pixel_q[$];
    t_splat_write splat_write_q[$];
    int           n_sent   = 0;
    int           n_taken  = 0;
    int           err_cnt  = 0;
    logic         in_taken = 1'b0;

    // Shadow registers of the warp map
    t_acc        org_x   = '0;
    t_acc        org_y   = '0;
    t_acc        cstep_x = t_acc'(64'h1_0000_0000);
    t_acc        cstep_y = '0;
    t_acc        rstep_x = '0;
    t_acc        rstep_y = t_acc'(64'h1_0000_0000);
    logic [3:0]  splat_w = 4'd1;
    logic [3:0]  splat_h = 4'd1;

    // Scan position of the predictor
    t_acc start_x   = '0;
    t_acc start_y   = '0;
    t_acc pos_x     = '0;
    t_acc pos_y     = '0;
    logic new_frame = 1'b1;

    // Burst shaping of the sender and stall pattern of the receiver
    int          gap_left   = 0;
    int          burst_left = 8;
    int          pat_cnt    = 0;
    logic [15:0] stall_pat  = '1;

    affine_pixel_splat_warp_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_pixel_color   (i_pixel_color),
        .i_end_of_row    (i_end_of_row),
        .i_end_of_frame  (i_end_of_frame),
        .empty           (empty),
        .pop             (pop),
        .o_write_address (o_write_address),
        .o_write_color   (o_write_color),
        .o_last_write    (o_last_write),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Integer part of a Q16.32 position, rounded toward zero
    function automatic longint trunc_int(input t_acc v);
        longint s;
        s = {{16{v[ACC_W-1]}}, v};
        if (s >= 0) begin
            return s >>> FRAC_W;
        end
        return -((-s) >>> FRAC_W);
    endfunction

    // Map a raw splat size register onto 1..MAX_SPLAT
    function automatic int splat_extent(input logic [3:0] r);
        if (r == 4'd0) begin
            return 1;
        end
        if (r > MAX_SPLAT) begin
            return int'(MAX_SPLAT);
        end
        return int'(r);
    endfunction

    // Work out the writes of one source pixel, then advance the scan position
    task automatic predict_splat(input t_pixel px);
        longint       col, row, lim_x, lim_y;
        int           w, h;
        t_splat_write wr;
        // a frame start reloads the scan from the origin as it stands now
        if (new_frame) begin
            start_x   = org_x;
            start_y   = org_y;
            pos_x     = org_x;
            pos_y     = org_y;
            new_frame = 1'b0;
        end
        w     = splat_extent(splat_w);
        h     = splat_extent(splat_h);
        col   = trunc_int(pos_x);
        row   = trunc_int(pos_y);
        lim_x = longint'(DEST_WIDTH) - w + 1;
        lim_y = longint'(DEST_HEIGHT) - h + 1;
        // the whole splat must fit; otherwise the pixel is dropped
        if (col >= 0 && col < lim_x && row >= 0 && row < lim_y) begin
            for (int v = 0; v < h; v++) begin
                for (int u = 0; u < w; u++) begin
                    wr.addr  = t_addr'((row + v) * longint'(DEST_WIDTH) + col + u);
                    wr.color = px.color;
                    wr.last  = (v == h - 1) && (u == w - 1);
                    splat_write_q.push_back(wr);
                end
            end
        end
        // frame end beats row end; accumulators wrap at 48 bits
        if (px.frame_end) begin
            new_frame = 1'b1;
        end else if (px.row_end) begin
            start_x = start_x + rstep_x;
            start_y = start_y + rstep_y;
            pos_x   = start_x;
            pos_y   = start_y;
        end else begin
            pos_x = pos_x + cstep_x;
            pos_y = pos_y + cstep_y;
        end
    endtask

    // ------------------------------------------------------------------------
    // Pixel driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : pixel_drv
        t_pixel px;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || in_taken) begin
            // the previous pixel is gone (or none was offered); pick the next step
            if (gap_left > 0) begin
                push     <= 1'b0;
                gap_left -= 1;
            end else if (pixel_q.size() != 0) begin
                px             = pixel_q.pop_front();
                push           <= 1'b1;
                i_pixel_color  <= px.color;
                i_end_of_row   <= px.row_end;
                i_end_of_frame <= px.frame_end;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                end else begin
                    burst_left -= 1;
                end
            end else begin
                push <= 1'b0;
            end
        end
        // otherwise hold push and the fields until the transfer happens
    end

    // ------------------------------------------------------------------------
    // Write receiver: pop follows a 16-bit rotating pattern reloaded at random;
    // half the patterns pop every cycle, the rest never stall for a full pattern
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : write_rcv
        logic [15:0] pat_next;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pat_next = stall_pat;
            if (pat_cnt == 0) begin
                case ($urandom_range(0, 3))
                    0, 1:    pat_next = '1;
                    2:       pat_next = 16'($urandom) | 16'h1;
                    default: pat_next = 16'($urandom & $urandom) | 16'h1;
                endcase
                pat_cnt = 16;
            end
            pop       <= pat_next[0];
            stall_pat <= {pat_next[0], pat_next[15:1]};
            pat_cnt   -= 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on every pixel transfer, check on every write transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : write_mon
        t_pixel       px;
        t_splat_write want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= push && !full;
            // predict first: a pixel's writes never leave in its own cycle
            if (push && !full) begin
                px.color     = i_pixel_color;
                px.row_end   = i_end_of_row;
                px.frame_end = i_end_of_frame;
                predict_splat(px);
                n_taken += 1;
            end
            if (pop && !empty) begin
                if (splat_write_q.size() == 0) begin
                    err_cnt += 1;
                    $display("%0t: unexpected write expected none actual addr %0h color %0h last %0b",
                             $time, o_write_address, o_write_color, o_last_write);
                end else begin
                    want = splat_write_q.pop_front();
                    if (o_write_address !== want.addr) begin
                        err_cnt += 1;
                        $display("%0t: write_address expected %0h actual %0h",
                                 $time, want.addr, o_write_address);
                    end
                    if (o_write_color !== want.color) begin
                        err_cnt += 1;
                        $display("%0t: write_color expected %0h actual %0h",
                                 $time, want.color, o_write_color);
                    end
                    if (o_last_write !== want.last) begin
                        err_cnt += 1;
                        $display("%0t: last_write expected %0b actual %0b",
                                 $time, want.last, o_last_write);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_acc to_q(input real r);
        return t_acc'(longint'(r * 4294967296.0));
    endfunction

    // Random Q16.32 value between two bounds given in thousandths, with
    // some noise in the low fraction bits
    function automatic t_acc rand_q(input int lo_milli, input int hi_milli);
        int m;
        m = lo_milli + int'($urandom_range(0, hi_milli - lo_milli));
        return to_q(real'(m) / 1000.0) + t_acc'($urandom_range(0, 1023));
    endfunction

    // Register write over the configuration port; unused upper data bits
    // carry noise since the block keeps only the register's width
    task automatic cfg_write(input t_reg_idx idx, input t_acc val);
        logic [PDATA_W-1:0] data;
        data = {$urandom, $urandom};
        if (idx == REG_SPLAT_W || idx == REG_SPLAT_H) begin
            data[SIZE_W-1:0] = val[SIZE_W-1:0];
        end else begin
            data[ACC_W-1:0] = val;
        end
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 3'b000});
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        case (idx)
            REG_ORIGIN_X:   org_x   = data[ACC_W-1:0];
            REG_ORIGIN_Y:   org_y   = data[ACC_W-1:0];
            REG_COL_STEP_X: cstep_x = data[ACC_W-1:0];
            REG_COL_STEP_Y: cstep_y = data[ACC_W-1:0];
            REG_ROW_STEP_X: rstep_x = data[ACC_W-1:0];
            REG_ROW_STEP_Y: rstep_y = data[ACC_W-1:0];
            REG_SPLAT_W:    splat_w = data[SIZE_W-1:0];
            REG_SPLAT_H:    splat_h = data[SIZE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_pixel(input t_color color, input logic eor, input logic eof);
        t_pixel px;
        px.color     = color;
        px.row_end   = eor;
        px.frame_end = eof;
        pixel_q.push_back(px);
        n_sent += 1;
    endtask

    // Hold until every pixel has transferred and every write has been popped,
    // then let dropped pixels still in the pipeline drain out
    task automatic wait_idle();
        while (n_taken != n_sent || splat_write_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (16) @(negedge i_clk);
    endtask

    // Random warp map; splats stay small most of the time
    task automatic rand_warp_setup();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            cfg_write(REG_ORIGIN_X, rand_q(-3000, 900000));
            cfg_write(REG_COL_STEP_X, rand_q(300, 2500));
        end else if (pick < 7) begin
            // scan right to left from the far side
            cfg_write(REG_ORIGIN_X, rand_q(400000, 1000000));
            cfg_write(REG_COL_STEP_X, rand_q(-2500, -300));
        end else if ($urandom_range(0, 3) != 0) begin
            // start near the right edge so the bound check bites
            cfg_write(REG_ORIGIN_X, rand_q(1000000, 1030000));
        end
        if ($urandom_range(0, 3) != 0) cfg_write(REG_ORIGIN_Y, rand_q(-3000, 950000));
        if ($urandom_range(0, 3) != 0) cfg_write(REG_COL_STEP_Y, rand_q(-400, 400));
        if ($urandom_range(0, 3) != 0) cfg_write(REG_ROW_STEP_X, rand_q(-400, 400));
        if ($urandom_range(0, 3) != 0) begin
            cfg_write(REG_ROW_STEP_Y, ($urandom_range(0, 5) == 0) ? rand_q(-3000, -300)
                                                                  : rand_q(300, 3000));
        end
        for (int k = 0; k < 2; k++) begin
            pick = $urandom_range(0, 9);
            cfg_write((k == 0) ? REG_SPLAT_W : REG_SPLAT_H,
                      (pick < 6) ? t_acc'($urandom_range(1, 2)) :
                      (pick < 8) ? t_acc'($urandom_range(3, 5)) :
                      (pick < 9) ? t_acc'($urandom_range(6, 8)) :
                      ($urandom_range(0, 1) != 0) ? t_acc'($urandom_range(9, 15)) : t_acc'(0));
        end
    endtask

    // One source frame: mostly clean raster order with row and frame marks,
    // sometimes noise marks, sometimes left open so the next phase continues it
    task automatic gen_frame();
        int   cols, rows;
        logic tidy, closed, eor, eof;
        cols   = $urandom_range(2, 12);
        rows   = $urandom_range(1, 5);
        tidy   = $urandom_range(0, 4) != 0;
        closed = $urandom_range(0, 5) != 0;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (tidy) begin
                    eof = closed && (r == rows - 1) && (c == cols - 1);
                    eor = (c == cols - 1) && (!eof || $urandom_range(0, 1) != 0);
                end else begin
                    eor = $urandom_range(0, 6) == 0;
                    eof = $urandom_range(0, 19) == 0;
                end
                queue_pixel($urandom, eor, eof);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset map, identity with 1x1 splats: color extremes, a row end,
        // row and frame end together, then a frame end alone
        queue_pixel(32'h0000_0000, 1'b0, 1'b0);
        queue_pixel(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_pixel($urandom,      1'b1, 1'b0);
        queue_pixel(32'hA5A5_A5A5, 1'b0, 1'b0);
        queue_pixel(32'h5A5A_5A5A, 1'b1, 1'b1);
        queue_pixel($urandom,      1'b0, 1'b1);
        wait_idle();

        // Small negative positions truncate to zero; width 0 acts as 1 and
        // height above the limit acts as the limit
        cfg_write(REG_ORIGIN_X, to_q(-0.5));
        cfg_write(REG_ORIGIN_Y, to_q(-0.75));
        cfg_write(REG_COL_STEP_Y, to_q(0.25));
        cfg_write(REG_SPLAT_W, t_acc'(0));
        cfg_write(REG_SPLAT_H, t_acc'(15));
        queue_pixel($urandom, 1'b0, 1'b0);
        queue_pixel($urandom, 1'b0, 1'b0);
        queue_pixel($urandom, 1'b0, 1'b1);
        wait_idle();

        // Accumulator wrap: the most negative column step and the most
        // positive row step bring the position back in bounds on wrap
        cfg_write(REG_ORIGIN_X, to_q(5.0));
        cfg_write(REG_ORIGIN_Y, to_q(2.0));
        cfg_write(REG_COL_STEP_X, t_acc'(48'h8000_0000_0000));
        cfg_write(REG_COL_STEP_Y, '0);
        cfg_write(REG_ROW_STEP_X, '0);
        cfg_write(REG_ROW_STEP_Y, t_acc'(48'h7FFF_FFFF_FFFF));
        cfg_write(REG_SPLAT_W, t_acc'(3));
        cfg_write(REG_SPLAT_H, t_acc'(2));
        queue_pixel($urandom, 1'b0, 1'b0);
        queue_pixel($urandom, 1'b0, 1'b0);
        queue_pixel($urandom, 1'b1, 1'b0);
        queue_pixel($urandom, 1'b1, 1'b0);
        queue_pixel($urandom, 1'b0, 1'b1);
        wait_idle();

        // Largest splat right at the bottom-right bound, then one column past it
        cfg_write(REG_ORIGIN_X, to_q(1016.0));
        cfg_write(REG_ORIGIN_Y, to_q(1016.999));
        cfg_write(REG_COL_STEP_X, to_q(1.0));
        cfg_write(REG_ROW_STEP_Y, to_q(1.0));
        cfg_write(REG_SPLAT_W, t_acc'(8));
        cfg_write(REG_SPLAT_H, t_acc'(8));
        queue_pixel($urandom, 1'b0, 1'b0);
        queue_pixel($urandom, 1'b0, 1'b1);
        wait_idle();

        // Random phases: new map, one or two frames, drain, repeat
        while (n_sent < 364) begin
            rand_warp_setup();
            repeat ($urandom_range(1, 2)) gen_frame();
            wait_idle();
        end

        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #30000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[affine_pixel_splat_warp_top.f]
design/apsw_pkg.sv
design/apsw_front.sv
design/apsw_queue.sv
design/apsw_back.sv
design/affine_pixel_splat_warp_top.sv
tb/tb_affine_pixel_splat_warp_top.sv
